// ----- sv/sul_pkg.sv -----
`timescale 1ns / 1ps
package sul_pkg;

    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int FIELD_WIDTH      = 32;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] seg_left;
        logic signed [FIELD_WIDTH-1:0] seg_right;
        logic                          last;
    } t_seg_in;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] covered_length;
        logic                   overflow_seen;
        logic                   bad_segment_seen;
    } t_seg_out;

endpackage

// ----- sv/sul_ram.sv -----
`timescale 1ns / 1ps
module sul_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/segment_union_length_top.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// request | in        | i_valid / o_stall     | i_data (t_seg_in)
// result  | out       | o_valid / i_stall     | o_data (t_seg_out)
//
// A request is taken only while the sequencer is idle; o_stall is high otherwise.
// An insert sifts the segment up the heap, and the sweep pops and sifts down; the steps
// share the single read port of the heap memory and the one comparator.
// A dropped request without the last flag leaves the sequencer idle.
// Reset is synchronous and active low; a result waits while the last one is stalled.
module segment_union_length_top #(
    parameter int MAX_SEGMENTS = sul_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = sul_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sul_pkg::t_seg_in   i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output sul_pkg::t_seg_out  o_data
);
    import sul_pkg::*;

    // Coordinates are held at no more than the field width.
    localparam int CW   = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;
    localparam int EW   = 2 * CW;
    localparam int AW   = $clog2(MAX_SEGMENTS);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_UPC, S_POP0, S_POP1, S_POP2,
        S_DN, S_DNL, S_DNR, S_DNC, S_RUN, S_RUN2, S_FIN
    } t_state;

    t_state                  r_state;
    logic [EW-1:0]           r_x;      // element being placed
    logic [EW-1:0]           r_c;      // smaller child seen so far
    logic [EW-1:0]           r_top;    // element just popped
    logic [AW-1:0]           r_i;
    logic [AW-1:0]           r_j;
    logic [CNTW-1:0]         r_count;
    logic                    r_last;
    logic                    r_have;
    logic signed [CW-1:0]    r_rl;
    logic signed [CW-1:0]    r_rr;
    logic [FIELD_WIDTH-1:0]  r_total;
    logic                    r_ovf;
    logic                    r_bad;
    logic                    r_out_valid;
    t_seg_out                r_out;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [EW-1:0]           ram_rdata;

    logic signed [CW-1:0]    cmp_a;
    logic signed [CW-1:0]    cmp_b;
    logic                    cmp_lt;

    logic                    acc;
    logic                    out_free;
    logic                    full;
    logic [AW:0]             child_l;
    logic [AW:0]             child_r;
    logic                    has_l;
    logic                    has_r;
    logic signed [CW-1:0]    in_l;
    logic signed [CW-1:0]    in_r;
    logic signed [FIELD_WIDTH-1:0] rl_ext;
    logic signed [FIELD_WIDTH-1:0] rr_ext;
    logic [FIELD_WIDTH-1:0]  run_len;

    function automatic logic signed [CW-1:0] key_of(input logic [EW-1:0] e);
        return $signed(e[EW-1:CW]);
    endfunction

    function automatic logic signed [CW-1:0] right_of(input logic [EW-1:0] e);
        return $signed(e[CW-1:0]);
    endfunction

    sul_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_heap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign acc      = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign full     = (r_count == CNTW'(MAX_SEGMENTS));
    assign in_l     = i_data.seg_left[CW-1:0];
    assign in_r     = i_data.seg_right[CW-1:0];

    // Children of the hole: 2i+1 and 2i+2, one bit wider than an address.
    assign child_l  = {r_i, 1'b1};
    assign child_r  = {1'b0, r_j} + (AW+1)'(1);
    assign has_l    = child_l < (AW+1)'(r_count);
    assign has_r    = child_r < (AW+1)'(r_count);

    // Length of the open run, taken modulo the result width.
    assign rl_ext   = FIELD_WIDTH'(r_rl);
    assign rr_ext   = FIELD_WIDTH'(r_rr);
    assign run_len  = rr_ext - rl_ext;

    // The one signed comparator that the steps of the sequencer share.
    always_comb begin
        cmp_a = in_r;
        cmp_b = in_l;
        unique case (r_state)
            S_UPC: begin
                cmp_a = key_of(r_x);
                cmp_b = key_of(ram_rdata);
            end
            S_DNR: begin
                cmp_a = key_of(ram_rdata);
                cmp_b = key_of(r_c);
            end
            S_DNC: begin
                cmp_a = key_of(r_c);
                cmp_b = key_of(r_x);
            end
            S_RUN: begin
                cmp_a = r_rr;
                cmp_b = key_of(r_top);
            end
            S_RUN2: begin
                cmp_a = r_rr;
                cmp_b = right_of(r_top);
            end
            default: begin
                cmp_a = in_r;
                cmp_b = in_l;
            end
        endcase
    end
    assign cmp_lt = cmp_a < cmp_b;

    // Memory port control for the current step.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = r_x;
        ram_raddr = '0;
        unique case (r_state)
            S_UP: begin
                if (r_i == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = (r_i - AW'(1)) >> 1;
                end
            end
            S_UPC: begin
                ram_we    = 1'b1;
                ram_wdata = cmp_lt ? ram_rdata : r_x;
            end
            S_POP1: begin
                ram_raddr = AW'(r_count - CNTW'(1));
            end
            S_DN: begin
                if (has_l) begin
                    ram_raddr = child_l[AW-1:0];
                end else begin
                    ram_we = 1'b1;
                end
            end
            S_DNL: begin
                ram_raddr = child_r[AW-1:0];
            end
            S_DNC: begin
                ram_we    = 1'b1;
                ram_wdata = cmp_lt ? r_c : r_x;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last      <= 1'b0;
            r_have      <= 1'b0;
            r_rl        <= '0;
            r_rr        <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The finishing step sets the result valid itself.
            if (!i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_last <= i_data.last;
                        if (cmp_lt) begin
                            r_bad   <= 1'b1;
                            r_state <= i_data.last ? S_POP0 : S_IDLE;
                        end else if (full) begin
                            r_ovf   <= 1'b1;
                            r_state <= i_data.last ? S_POP0 : S_IDLE;
                        end else begin
                            r_x     <= {in_l, in_r};
                            r_i     <= r_count[AW-1:0];
                            r_count <= r_count + CNTW'(1);
                            r_state <= S_UP;
                        end
                    end
                end
                S_UP: begin
                    if (r_i == '0) begin
                        r_state <= r_last ? S_POP0 : S_IDLE;
                    end else begin
                        r_state <= S_UPC;
                    end
                end
                S_UPC: begin
                    if (cmp_lt) begin
                        r_i     <= (r_i - AW'(1)) >> 1;
                        r_state <= S_UP;
                    end else begin
                        r_state <= r_last ? S_POP0 : S_IDLE;
                    end
                end
                S_POP0: begin
                    r_state <= (r_count == '0) ? S_FIN : S_POP1;
                end
                S_POP1: begin
                    r_top   <= ram_rdata;
                    r_count <= r_count - CNTW'(1);
                    r_state <= S_POP2;
                end
                S_POP2: begin
                    r_x     <= ram_rdata;
                    r_i     <= '0;
                    r_state <= (r_count == '0) ? S_RUN : S_DN;
                end
                S_DN: begin
                    if (has_l) begin
                        r_j     <= child_l[AW-1:0];
                        r_state <= S_DNL;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_DNL: begin
                    r_c     <= ram_rdata;
                    r_state <= has_r ? S_DNR : S_DNC;
                end
                S_DNR: begin
                    if (cmp_lt) begin
                        r_c <= ram_rdata;
                        r_j <= child_r[AW-1:0];
                    end
                    r_state <= S_DNC;
                end
                S_DNC: begin
                    if (cmp_lt) begin
                        r_i     <= r_j;
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!r_have || cmp_lt) begin
                        if (r_have) begin
                            r_total <= r_total + run_len;
                        end
                        r_have  <= 1'b1;
                        r_rl    <= key_of(r_top);
                        r_rr    <= right_of(r_top);
                        r_state <= S_POP0;
                    end else begin
                        r_state <= S_RUN2;
                    end
                end
                S_RUN2: begin
                    if (cmp_lt) begin
                        r_rr <= right_of(r_top);
                    end
                    r_state <= S_POP0;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out.covered_length   <= r_have ? r_total + run_len : r_total;
                        r_out.overflow_seen    <= r_ovf;
                        r_out.bad_segment_seen <= r_bad;
                        r_out_valid <= 1'b1;
                        r_count     <= '0;
                        r_last      <= 1'b0;
                        r_have      <= 1'b0;
                        r_rl        <= '0;
                        r_rr        <= '0;
                        r_total     <= '0;
                        r_ovf       <= 1'b0;
                        r_bad       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The heap never holds more segments than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_SEGMENTS))
        else $error("heap count beyond capacity");

    // Between sets no run is open and no length is pending.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_last) |-> (!r_have && r_total == '0))
        else $error("sweep state left over in idle");

    // Handing out a result leaves the heap empty and the result shown.
    a_fin_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_count == '0 && o_valid))
        else $error("result without emptied heap");
endmodule

// ----- tb/segment_union_length_checker.sv -----
`timescale 1ns / 1ps
module segment_union_length_checker #(
    parameter int MAX_SEGMENTS = sul_pkg::MAX_SEGMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  sul_pkg::t_seg_in  i_data,
    input  logic              i_out_valid,
    input  logic              i_stall_out,
    input  sul_pkg::t_seg_out i_out_data,
    output int                o_fail_count,
    output int                o_pending
);
    import sul_pkg::*;

    // Stored segments kept sorted by left end, so the sweep needs no heap.
    logic signed [FIELD_WIDTH-1:0] held_left[$];
    logic signed [FIELD_WIDTH-1:0] held_right[$];
    bit       full_drop;
    bit       reversed_drop;
    t_seg_out lengths_due[$];
    int       fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = lengths_due.size();

    task automatic take_segment(input t_seg_in seg);
        int       pos;
        longint   run_l, run_r, total;
        t_seg_out due;
        if (seg.seg_right < seg.seg_left) begin
            reversed_drop = 1'b1;
        end else if (held_left.size() >= MAX_SEGMENTS) begin
            full_drop = 1'b1;
        end else begin
            pos = held_left.size();
            while (pos > 0 && held_left[pos-1] > seg.seg_left) pos--;
            held_left.insert(pos, seg.seg_left);
            held_right.insert(pos, seg.seg_right);
        end
        if (seg.last) begin
            total = 0;
            for (int k = 0; k < held_left.size(); k++) begin
                if (k == 0) begin
                    run_l = held_left[k];
                    run_r = held_right[k];
                end else if (longint'(held_left[k]) > run_r) begin
                    total += run_r - run_l;
                    run_l = held_left[k];
                    run_r = held_right[k];
                end else if (longint'(held_right[k]) > run_r) begin
                    run_r = held_right[k];
                end
            end
            if (held_left.size() > 0) total += run_r - run_l;
            due.covered_length   = total[FIELD_WIDTH-1:0];
            due.overflow_seen    = full_drop;
            due.bad_segment_seen = reversed_drop;
            lengths_due.push_back(due);
            held_left.delete();
            held_right.delete();
            full_drop     = 1'b0;
            reversed_drop = 1'b0;
        end
    endtask

    task automatic note_failure(input string what, input t_seg_out want, input t_seg_out got);
        if (fail_count < 10) begin
            $display("%t mismatch (%s): expected len=%0d ovf=%0b bad=%0b, got len=%0d ovf=%0b bad=%0b",
                $realtime, what, want.covered_length, want.overflow_seen, want.bad_segment_seen,
                got.covered_length, got.overflow_seen, got.bad_segment_seen);
        end
        fail_count++;
    endtask

    initial begin
        fail_count    = 0;
        full_drop     = 1'b0;
        reversed_drop = 1'b0;
    end

    always @(posedge i_clk) begin
        t_seg_out want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) take_segment(i_data);
            if (i_out_valid && !i_stall_out) begin
                if (lengths_due.size() == 0) begin
                    note_failure("unexpected result", '0, i_out_data);
                end else begin
                    want = lengths_due.pop_front();
                    if (want !== i_out_data) note_failure("field", want, i_out_data);
                end
            end
        end
    end

endmodule

// ----- tb/tb_segment_union_length_top.sv -----
`timescale 1ns / 1ps
module tb_segment_union_length_top;
    import sul_pkg::*;

    localparam int CAPACITY = MAX_SEGMENTS_DEF;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_seg_in  i_data;
    logic     o_valid;
    logic     i_stall;
    t_seg_out o_data;
    int       fail_count;
    int       pending;
    int       items_sent;
    bit       long_hold_wanted;

    segment_union_length_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // The checker sits beside the block and sees both channels exactly as it does.
    segment_union_length_checker #(.MAX_SEGMENTS(CAPACITY)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_data       (i_data),
        .i_out_valid  (o_valid),
        .i_stall_out  (i_stall),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a run that has not finished by this time reports failure.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // Offers one request after a random gap and holds it until the block takes it.
    // Valid is only lowered when there really is a gap, so that a back-to-back
    // request never sees valid dropped and raised within the same time step.
    task automatic send_segment(input logic signed [31:0] left, input logic signed [31:0] right,
                                input logic last);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_data.seg_left  <= left;
        i_data.seg_right <= right;
        i_data.last      <= last;
        i_valid          <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Draws one segment. Narrow coordinates give plenty of overlap, touching and
    // nesting; the wide ones exercise every bit and the total taken modulo 32 bits.
    task automatic send_random(input logic last, input int broken_pct);
        logic signed [31:0] a, b, t;
        if ($urandom_range(0, 3) == 0) begin
            a = $urandom();
            b = $urandom();
        end else begin
            a = $signed($urandom_range(0, 200)) - 100;
            b = a + $urandom_range(0, 30);
        end
        if (b < a) begin
            t = a;
            a = b;
            b = t;
        end
        // A reversed segment is broken input and must be dropped and flagged.
        if (a != b && $urandom_range(0, 99) < broken_pct) send_segment(b, a, last);
        else send_segment(a, b, last);
    endtask

    task automatic send_set(input int count, input int broken_pct);
        for (int k = 0; k < count; k++) send_random(k == count - 1, broken_pct);
    endtask

    // Receiver: stalls for a random number of cycles before each result, and once
    // holds off for a long stretch so that the block backs up onto its input.
    initial begin
        int hold;
        i_stall <= 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_wanted) begin
                long_hold_wanted = 1'b0;
                i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
            end else begin
                hold = $urandom_range(0, 12);
                if ($urandom_range(0, 3) == 0) hold = 0;
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int wait_cycles;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data           <= '0;
        items_sent       = 0;
        long_hold_wanted = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: widest possible segment, whose length needs all 32 bits.
        send_segment(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
        // Zero-length segment, then a reversed one alone, which leaves an empty set.
        send_segment(5, 5, 1'b1);
        send_segment(10, -10, 1'b1);
        // Touching, nested, disjoint and equal left ends in one set.
        send_segment(0, 10, 1'b0);
        send_segment(10, 20, 1'b0);
        send_segment(3, 7, 1'b0);
        send_segment(40, 50, 1'b0);
        send_segment(40, 45, 1'b0);
        send_segment(-30, -20, 1'b0);
        send_segment(32'sh7fff_fff0, 32'sh7fff_ffff, 1'b0);
        send_segment(32'sh8000_0000, 32'sh8000_0001, 1'b1);
        // Arrival order reversed against left end, with a reversed segment mixed in.
        send_segment(100, 110, 1'b0);
        send_segment(50, 60, 1'b0);
        send_segment(7, 6, 1'b0);
        send_segment(-5, 55, 1'b1);
        // Two segments a gap of one apart, whose lengths sum to 2^32 - 2 and still fit in 32 bits.
        send_segment(32'sh8000_0000, 32'sh0000_0000, 1'b0);
        send_segment(32'sh0000_0001, 32'sh7fff_ffff, 1'b1);

        // Random small sets, with the long receiver hold-off in the middle of them.
        for (int s = 0; s < 12; s++) send_set($urandom_range(1, 24), 5);
        long_hold_wanted = 1'b1;
        for (int s = 0; s < 6; s++) send_set($urandom_range(1, 4), 5);

        // One set past capacity, so the full-heap drop is seen.
        send_set(CAPACITY + 3, 0);

        while (items_sent < 1350) send_set($urandom_range(1, 24), 5);

        @(posedge i_clk);
        i_valid <= 1'b0;

        // Drain: a full sweep is slow, so allow plenty before giving up.
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
